// ----- hw/rtl/pdfq_pkg.sv -----
// shared types and constants for the per-destination fragmenting queue
package pdfq_pkg;

	localparam int unsigned NUM_DEST_DEF    = 8;
	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam logic [31:0] MAX_CHUNK_RESET = 32'd1202;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_EMITTED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_DEQUEUE = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] destination;
		logic [31:0] identifier;
		logic [7:0]  priority_level;
		logic [31:0] packet_type;
		logic [31:0] window;
		logic [31:0] start_offset;
		logic [31:0] payload_size;
		logic [31:0] ack_received;
		logic [31:0] ack_sent;
		logic [31:0] ack_size;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] out_destination;
		logic [31:0] out_identifier;
		logic [31:0] out_type;
		logic [31:0] out_window;
		logic [31:0] out_offset;
		logic [31:0] out_length;
		logic [31:0] out_ack_received;
		logic [31:0] out_ack_sent;
		logic [31:0] out_ack_size;
		logic        packet_done;
	} out_item_t;

	// one stored descriptor, as held in the entry memory
	typedef struct packed {
		logic [31:0] destination;
		logic [31:0] identifier;
		logic [7:0]  priority_level;
		logic [31:0] packet_type;
		logic [31:0] window;
		logic [31:0] start_offset;
		logic [31:0] payload_size;
		logic [31:0] ack_received;
		logic [31:0] ack_sent;
		logic [31:0] ack_size;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ----- hw/rtl/pdfq_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module pdfq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/pdfq_front.sv -----
// front end: input buffer queue between acceptance and execution
module pdfq_front import pdfq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output in_item_t cmd_item
);

	// two-entry queue so the front keeps accepting while the back works
	in_item_t buf_q [2];
	logic     rd_ptr_q;
	logic     wr_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	logic pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_item  = buf_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop  = cmd_valid && cmd_ready;

	// payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- hw/rtl/pdfq_back.sv -----
// back end: slot table, entry memory, head scan and fragmentation
module pdfq_back import pdfq_pkg::*; #(
	parameter int unsigned NUM_DEST    = NUM_DEST_DEF,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] max_chunk,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  in_item_t    cmd_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	localparam int unsigned SW = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;
	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned AW = SW + PW;
	localparam int unsigned MD = 2 ** AW;

	typedef enum logic [3:0] {
		S_IDLE, S_ENQ, S_SCAN, S_SCAN_RD, S_SCAN_CMP, S_FIN_RD, S_FIN_WAIT, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	in_item_t cmd_q;

	logic [31:0]   tag_q   [NUM_DEST];
	logic          valid_q [NUM_DEST];
	logic [CW-1:0] count_q [NUM_DEST];
	logic [PW-1:0] head_q  [NUM_DEST];
	logic [PW-1:0] tail_q  [NUM_DEST];

	// scan bookkeeping
	logic [NUM_DEST-1:0] used_q;
	logic          have_sel_q;
	logic [SW-1:0] sel_q;
	logic [SW-1:0] cand_q;
	logic [7:0]    sel_pri_q;
	logic [31:0]   sel_type_q;
	logic [31:0]   sel_id_q;
	out_item_t     res_q;

	// ram interface
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t        rd_e;

	assign rd_e = entry_t'(ram_rdata);

	pdfq_ram #(.WIDTH(ENTRY_W), .DEPTH(MD)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// slot match and first free slot for enqueue
	logic          hit;
	logic [SW-1:0] hit_idx;
	logic          free;
	logic [SW-1:0] free_idx;
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		free = 1'b0;
		free_idx = '0;
		for (int i = NUM_DEST - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == cmd_q.destination) begin
				hit = 1'b1;
				hit_idx = SW'(i);
			end
			if (!valid_q[i]) begin
				free = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	// next candidate: smallest tag among occupied, unvisited slots
	logic          cand_ok;
	logic [SW-1:0] cand_idx;
	always_comb begin
		cand_ok = 1'b0;
		cand_idx = '0;
		for (int i = 0; i < NUM_DEST; i++) begin
			if (valid_q[i] && !used_q[i] &&
			    (!cand_ok || tag_q[i] < tag_q[cand_idx])) begin
				cand_ok = 1'b1;
				cand_idx = SW'(i);
			end
		end
	end

	// fragment arithmetic on the winner's head entry
	logic [31:0] rem;
	logic [31:0] frag_len;
	logic [31:0] new_off;
	logic        frag;
	assign frag     = rd_e.window > max_chunk;
	assign rem      = rd_e.window - rd_e.start_offset;
	assign frag_len = (rem < max_chunk) ? rem : max_chunk;
	assign new_off  = rd_e.start_offset + frag_len;

	logic [SW-1:0] e_slot;
	assign e_slot = hit ? hit_idx : free_idx;

	// ram address and write data selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {e_slot, tail_q[e_slot]};
		ram_wdata = '{destination: cmd_q.destination, identifier: cmd_q.identifier,
			priority_level: cmd_q.priority_level, packet_type: cmd_q.packet_type,
			window: cmd_q.window, start_offset: cmd_q.start_offset,
			payload_size: cmd_q.payload_size, ack_received: cmd_q.ack_received,
			ack_sent: cmd_q.ack_sent, ack_size: cmd_q.ack_size};
		ram_raddr = {cand_q, head_q[cand_q]};
		unique case (state_q)
			S_ENQ: begin
				ram_we = (hit || free) && (!hit || count_q[hit_idx] < CW'(QUEUE_DEPTH));
				if (!hit) ram_waddr = {free_idx, PW'(0)};
			end
			// hold the winner's address until its entry reaches the read register
			S_FIN_RD, S_FIN_WAIT: ram_raddr = {sel_q, head_q[sel_q]};
			S_FIN: begin
				ram_we = frag && (new_off != rd_e.window);
				ram_waddr = {sel_q, head_q[sel_q]};
				ram_wdata = rd_e;
				ram_wdata.start_offset = new_off;
			end
			default: ;
		endcase
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_item  = res_q;

	// head advance helper
	function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
		wrap_next = ({1'b0, p} + 1'b1 >= (PW + 1)'(QUEUE_DEPTH)) ? '0 : p + 1'b1;
	endfunction

	// sequencer, slot table and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= '0;
			res_q      <= '0;
			used_q     <= '0;
			have_sel_q <= 1'b0;
			sel_q      <= '0;
			cand_q     <= '0;
			sel_pri_q  <= '0;
			sel_type_q <= '0;
			sel_id_q   <= '0;
			for (int i = 0; i < NUM_DEST; i++) begin
				tag_q[i]   <= '0;
				valid_q[i] <= 1'b0;
				count_q[i] <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd_item;
						used_q <= '0;
						have_sel_q <= 1'b0;
						state_q <= (cmd_item.command == CMD_ENQUEUE) ? S_ENQ : S_SCAN;
					end
				end
				S_ENQ: begin
					if (!(hit || free) || (hit && count_q[hit_idx] >= CW'(QUEUE_DEPTH))) begin
						res_q <= '{status: ST_DROPPED, default: '0};
					end else begin
						res_q <= '{status: ST_ENQUEUED, default: '0};
						valid_q[e_slot] <= 1'b1;
						tag_q[e_slot] <= cmd_q.destination;
						if (hit) begin
							tail_q[e_slot]  <= wrap_next(tail_q[e_slot]);
							count_q[e_slot] <= count_q[e_slot] + 1'b1;
						end else begin
							head_q[e_slot]  <= '0;
							tail_q[e_slot]  <= wrap_next('0);
							count_q[e_slot] <= CW'(1);
						end
					end
					state_q <= S_OUT;
				end
				S_SCAN: begin
					if (cand_ok) begin
						used_q[cand_idx] <= 1'b1;
						cand_q <= cand_idx;
						state_q <= S_SCAN_RD;
					end else if (have_sel_q) begin
						state_q <= S_FIN_RD;
					end else begin
						res_q <= '{status: ST_EMPTY, default: '0};
						state_q <= S_OUT;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CMP;
				S_SCAN_CMP: begin
					if (!have_sel_q ||
					    (sel_pri_q == rd_e.priority_level && sel_type_q < rd_e.packet_type) ||
					    (sel_pri_q > rd_e.priority_level) ||
					    (sel_id_q > rd_e.identifier)) begin
						have_sel_q <= 1'b1;
						sel_q      <= cand_q;
						sel_pri_q  <= rd_e.priority_level;
						sel_type_q <= rd_e.packet_type;
						sel_id_q   <= rd_e.identifier;
					end
					state_q <= S_SCAN;
				end
				S_FIN_RD: state_q <= S_FIN_WAIT;
				S_FIN_WAIT: state_q <= S_FIN;
				S_FIN: begin
					res_q.status           <= ST_EMITTED;
					res_q.out_destination  <= rd_e.destination;
					res_q.out_identifier   <= rd_e.identifier;
					res_q.out_type         <= rd_e.packet_type;
					res_q.out_window       <= rd_e.window;
					res_q.out_offset       <= rd_e.start_offset;
					res_q.out_ack_received <= rd_e.ack_received;
					res_q.out_ack_sent     <= rd_e.ack_sent;
					res_q.out_ack_size     <= rd_e.ack_size;
					res_q.out_length       <= frag ? frag_len : rd_e.payload_size;
					res_q.packet_done      <= !frag || (new_off == rd_e.window);
					if (!frag || (new_off == rd_e.window)) begin
						head_q[sel_q]  <= wrap_next(head_q[sel_q]);
						count_q[sel_q] <= count_q[sel_q] - 1'b1;
						if (count_q[sel_q] == CW'(1)) valid_q[sel_q] <= 1'b0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/per_destination_fragmenting_queue.sv -----
// top level of the per-destination fragmenting queue
// enqueue: accept, slot update, result; dequeue: head scan over the occupied slots, then head read, fragment, result
// dequeue with nothing queued: an empty scan, then result; head scan visits each slot in steps (select, read, compare)
// one item in the back end at a time; a two-entry input queue keeps accepting meanwhile
// reset: all slots free, max_chunk back to 1202; entry memory holds no reset value
module per_destination_fragmenting_queue import pdfq_pkg::*; #(
	parameter int unsigned NUM_DEST    = NUM_DEST_DEF,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	logic [31:0] max_chunk_q;
	logic        cmd_valid;
	logic        cmd_ready;
	in_item_t    cmd_item;

	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q <= MAX_CHUNK_RESET;
		end else if (cfg_valid) begin
			max_chunk_q <= cfg_data;
		end
	end

	pdfq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item)
	);

	pdfq_back #(.NUM_DEST(NUM_DEST), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_chunk (max_chunk_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_data)
	);

endmodule
